// File: rtl/mwsd_pkg.sv
// Package for the multiword short divider: payload structs, operation and
// register codes, and the request/response structs of the shared divider.
// No dependencies.
package mwsd_pkg;

    localparam int DIGIT_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W    = 7;   // holds up to 2*DIGIT_W iterations

    localparam logic [1:0] OP_QUOT = 2'd0;
    localparam logic [1:0] OP_FRAC = 2'd1;
    localparam logic [1:0] OP_REM  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_DIGITS = 1'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic [DIGIT_W-1:0] digit;
        logic               first;
        logic [DIGIT_W-1:0] start_remainder;
        logic               last;
    } in_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] quotient_digit;
        logic [COUNT_W-1:0] position;
        logic [DIGIT_W-1:0] remainder;
        logic [COUNT_W-1:0] leading_zeros;
        logic               done_res;
    } out_t;

    typedef struct packed {
        logic               start;
        logic [DIGIT_W-1:0] hi;
        logic [DIGIT_W-1:0] lo;
        logic [DIGIT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [DIGIT_W-1:0] quotient;
        logic               quotient_hi;   // high quotient word is nonzero
        logic [DIGIT_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: rtl/multiword_short_divider.sv
// Top level of the multiword short divider: digit sequencer, configuration
// registers and output register around the shared bit-serial divider.
// Depends on mwsd_pkg and mwsd_div_unit.

// Schoolbook short division of a multi-digit number by a 32-bit divisor,
// digits most significant first. Each accepted digit forms
// remainder*2^32 + digit and runs through one bit-serial restoring divider,
// one quotient bit per cycle. A digit that needs a division goes through an
// accept step, divider iterations over the low 32 dividend bits, and a step
// that updates the state and loads the output register. When the running
// remainder is not below the divisor (only possible with a large start
// remainder in quotient mode) the divider iterates over all 64 dividend
// bits. A zero divisor needs no iterations. A digit that is ignored (idle,
// unused operation, finished number) is taken without starting the divider.
// The output register holds a finished result while the next digit is
// accepted; completion waits only if that register is still full and
// m_ready is low when the divider is done. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; index 0 is the divisor, index 1 the
// number of significant digits in fractional mode.
module multiword_short_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [mwsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mwsd_pkg::DIGIT_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mwsd_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mwsd_pkg::out_t                m_data
);
    import mwsd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    // configuration
    logic [DIGIT_W-1:0] divisor_reg;
    logic [COUNT_W-1:0] result_digits_reg;

    // sequencer state
    logic               state_reg, state_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [1:0]         op_reg, op_next;
    logic [COUNT_W-1:0] dleft_reg, dleft_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic [COUNT_W-1:0] zcnt_reg, zcnt_next;
    logic               emit_reg, emit_next;
    logic               fin_reg, fin_next;
    logic               last_reg, last_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               s_fire;
    logic               out_free;
    logic               complete;
    logic [COUNT_W-1:0] dleft_dec;

    mwsd_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    // divider idle and room in the output register
    assign complete = (state_reg == ST_DIV) && !div_rsp.busy && out_free;
    assign dleft_dec = dleft_reg - 1'b1;

    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        op_next      = op_reg;
        dleft_next   = dleft_reg;
        pos_next     = pos_reg;
        zcnt_next    = zcnt_reg;
        emit_next    = emit_reg;
        fin_next     = fin_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        div_req.start   = 1'b0;
        div_req.hi      = rem_reg;
        div_req.lo      = s_data.digit;
        div_req.divisor = divisor_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    last_next = s_data.last;
                    if (s_data.first) begin
                        // new number; a first digit restarts even mid-number
                        op_next    = s_data.func;
                        fin_next   = 1'b0;
                        pos_next   = '0;
                        zcnt_next  = '0;
                        emit_next  = 1'b0;
                        dleft_next = result_digits_reg;
                        rem_next   = (s_data.func == OP_QUOT) ? s_data.start_remainder : '0;
                        if ((s_data.func != OP_QUOT && s_data.func != OP_FRAC &&
                             s_data.func != OP_REM) ||
                            (s_data.func == OP_FRAC && result_digits_reg == '0)) begin
                            fin_next = 1'b1;
                        end
                    end
                    if (!fin_next) begin
                        div_req.start = 1'b1;
                        div_req.hi    = rem_next;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (complete) begin
                    state_next = ST_IDLE;
                    rem_next   = div_rsp.remainder;
                    case (op_reg)
                        OP_QUOT: begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{quotient_digit: div_rsp.quotient,
                                             position:       pos_reg,
                                             remainder:      div_rsp.remainder,
                                             leading_zeros:  '0,
                                             done_res:       last_reg};
                            pos_next = pos_reg + 1'b1;
                            if (last_reg) begin
                                fin_next = 1'b1;
                            end
                        end
                        OP_FRAC: begin
                            // a wide quotient counts as significant even if
                            // its low word is zero
                            if (emit_reg || div_rsp.quotient != '0 ||
                                div_rsp.quotient_hi) begin
                                emit_next    = 1'b1;
                                dleft_next   = dleft_dec;
                                m_valid_next = 1'b1;
                                m_data_next  = '{quotient_digit: div_rsp.quotient,
                                                 position:       dleft_dec,
                                                 remainder:      div_rsp.remainder,
                                                 leading_zeros:  zcnt_reg,
                                                 done_res:       (dleft_dec == '0)};
                                if (dleft_dec == '0) begin
                                    fin_next = 1'b1;
                                end
                            end else if (zcnt_reg != '1) begin
                                // leading zero digit, count saturates
                                zcnt_next = zcnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            // remainder only: one result on the last digit
                            if (last_reg) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{quotient_digit: '0,
                                                 position:       '0,
                                                 remainder:      div_rsp.remainder,
                                                 leading_zeros:  '0,
                                                 done_res:       1'b1};
                                fin_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg       <= DIGIT_W'(1);
            result_digits_reg <= COUNT_W'(1);
            state_reg         <= ST_IDLE;
            rem_reg           <= '0;
            op_reg            <= OP_QUOT;
            dleft_reg         <= '0;
            pos_reg           <= '0;
            zcnt_reg          <= '0;
            emit_reg          <= 1'b0;
            fin_reg           <= 1'b1;
            last_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DIVISOR:       divisor_reg       <= cfg_wdata;
                    CFG_RESULT_DIGITS: result_digits_reg <= cfg_wdata[COUNT_W-1:0];
                    default:           ;
                endcase
            end
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            op_reg      <= op_next;
            dleft_reg   <= dleft_next;
            pos_reg     <= pos_next;
            zcnt_reg    <= zcnt_next;
            emit_reg    <= emit_next;
            fin_reg     <= fin_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/mwsd_div_unit.sv
// Bit-serial restoring divider: {hi,lo} / divisor, one quotient bit per cycle.
// Keeps the low word of the quotient, a nonzero flag for its high word and the
// full remainder. Depends on mwsd_pkg.
module mwsd_div_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  mwsd_pkg::div_req_t req,
    output mwsd_pkg::div_rsp_t rsp
);
    import mwsd_pkg::*;

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIGIT_W-1:0]   r_reg, r_next;
    logic [DIGIT_W-1:0]   q_reg, q_next;
    logic                 qhi_reg, qhi_next;
    logic [2*DIGIT_W-1:0] sh_reg, sh_next;
    logic [DIGIT_W-1:0]   div_reg, div_next;
    logic [DIGIT_W:0]     r_shift;
    logic [DIGIT_W:0]     r_sub;
    logic                 ge;

    always_comb begin
        r_shift = {r_reg, sh_reg[2*DIGIT_W-1]};
        ge      = r_shift >= {1'b0, div_reg};
        r_sub   = r_shift - {1'b0, div_reg};

        cnt_next = cnt_reg;
        r_next   = r_reg;
        q_next   = q_reg;
        qhi_next = qhi_reg;
        sh_next  = sh_reg;
        div_next = div_reg;

        if (req.start) begin
            div_next = req.divisor;
            q_next   = '0;
            qhi_next = 1'b0;
            if (req.divisor == '0) begin
                // zero divisor: all-ones quotient, remainder is the low word
                q_next   = '1;
                r_next   = req.lo;
                cnt_next = '0;
            end else if (req.hi < req.divisor) begin
                // high quotient word is zero, skip its iterations
                r_next   = req.hi;
                sh_next  = {req.lo, {DIGIT_W{1'b0}}};
                cnt_next = CNT_W'(DIGIT_W);
            end else begin
                // hi >= divisor: high quotient word is at least one
                qhi_next = 1'b1;
                r_next   = '0;
                sh_next  = {req.hi, req.lo};
                cnt_next = CNT_W'(2 * DIGIT_W);
            end
        end else if (cnt_reg != '0) begin
            r_next   = ge ? r_sub[DIGIT_W-1:0] : r_shift[DIGIT_W-1:0];
            q_next   = {q_reg[DIGIT_W-2:0], ge};
            sh_next  = {sh_reg[2*DIGIT_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        r_reg   <= r_next;
        q_reg   <= q_next;
        qhi_reg <= qhi_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
    end

    assign rsp.busy        = (cnt_reg != '0);
    assign rsp.quotient    = q_reg;
    assign rsp.quotient_hi = qhi_reg;
    assign rsp.remainder   = r_reg;

endmodule
